@@ src/ipacl_pkg.sv @@
// Shared types and constants for the IP subnet access list.
// Holds the input and result beat layouts, table entry layout and code enums.
// No dependencies.
package ipacl_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam logic [63:0] IPV4_MASK   = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_LOCK  = 2'd2,
    FN_CHECK = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_LOCKED = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_BLACK = 2'd1,
    MODE_WHITE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    func_e       func;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
  } in_t;

  typedef struct packed {
    logic    allowed;
    status_e status;
  } out_t;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] subnet_hi;
    logic [63:0] subnet_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
  } entry_t;

endpackage

@@ src/ipacl_table.sv @@
// Entry store of the access list: one synchronous memory, one write and one
// read port, read data registered. Depends on ipacl_pkg for the entry layout.
module ipacl_table #(
  parameter int unsigned ENTRIES = ipacl_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  ipacl_pkg::entry_t   wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output ipacl_pkg::entry_t   rdata_o
);

  ipacl_pkg::entry_t mem_q [ENTRIES];
  ipacl_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ip_subnet_access_list.sv @@
// IP subnet access list: top level with control sequencer and output register.
// Depends on ipacl_pkg and ipacl_table.
//
// Usage:
//   Input beats (in_valid_i / in_i / in_stall_o) carry one operation each:
//   add an entry, clear the table, lock the table or check an address.
//   Every input beat gives exactly one result beat (out_valid_o / out_o /
//   out_stall_i) with the allowed flag and a status code.
//   The mode register is written through cfg_valid_i / cfg_data_i; the port
//   is always ready, and a write is dropped once the table is locked.
// Timing:
//   Clear, lock, refused adds and checks that need no lookup pass from the result
//   register to the output register with no table walk. Adds and list checks walk
//   the stored entries through the single read port, one per cycle. One operation
//   is in flight at a time; the next beat is taken the cycle after the result
//   moves to the output register.
// Reset:
//   rst_ni clears the table count, the lock and the mode. Memory contents are
//   not cleared; only entries below the count are ever read.
// Back-pressure:
//   A stalled result holds in the output register; the sequencer then waits
//   with its finished result and in_stall_o stays high.
module ip_subnet_access_list #(
  parameter int unsigned ENTRIES = ipacl_pkg::ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ipacl_pkg::in_t  in_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output ipacl_pkg::out_t out_o,
  input  logic            out_stall_i,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_data_i,
  output logic            cfg_ready_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  ipacl_pkg::state_e state_q, state_d;
  ipacl_pkg::in_t    item_q, item_d;
  ipacl_pkg::out_t   res_q, res_d;
  ipacl_pkg::out_t   out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              locked_q, locked_d;
  logic [1:0]        mode_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              rd_vld_q, rd_vld_d;
  logic              hit_q, hit_d;

  ipacl_pkg::in_t    in_m;
  ipacl_pkg::entry_t item_entry;
  ipacl_pkg::entry_t rdata;
  logic              tbl_we;
  logic              tbl_re;
  logic              match;
  logic              out_free;

  // Table walk: read issued from rd_ptr_q, data compared in the cycle after.
  // The only write lands at the end of a walk, so a later read never races it.
  ipacl_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (item_entry),
    .re_i    (tbl_re),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Drop the unused upper bits of IPv4 beats so they store and compare as zero.
  always_comb begin
    in_m = in_i;
    if (!in_i.is_v6) begin
      in_m.addr_hi = '0;
      in_m.mask_hi = '0;
      in_m.addr_lo = in_i.addr_lo & ipacl_pkg::IPV4_MASK;
      in_m.mask_lo = in_i.mask_lo & ipacl_pkg::IPV4_MASK;
    end
  end

  assign item_entry = '{is_v6:     item_q.is_v6,
                        subnet_hi: item_q.addr_hi,
                        subnet_lo: item_q.addr_lo,
                        mask_hi:   item_q.mask_hi,
                        mask_lo:   item_q.mask_lo};

  // Add looks for an exact duplicate, check for a subnet hit of the same type.
  always_comb begin
    if (item_q.func == ipacl_pkg::FN_ADD) begin
      match = (rdata == item_entry);
    end else begin
      match = (rdata.is_v6 == item_q.is_v6) &&
              ((item_q.addr_hi & rdata.mask_hi) == (rdata.subnet_hi & rdata.mask_hi)) &&
              ((item_q.addr_lo & rdata.mask_lo) == (rdata.subnet_lo & rdata.mask_lo));
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Sequencer: next state, table control and result.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    locked_d    = locked_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    in_stall_o  = 1'b1;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ipacl_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d   = in_m;
          res_d    = '{allowed: 1'b0, status: ipacl_pkg::ST_DONE};
          rd_ptr_d = '0;
          hit_d    = 1'b0;
          state_d  = ipacl_pkg::S_DONE;
          case (in_i.func)
            ipacl_pkg::FN_ADD: begin
              if (locked_q) begin
                res_d.status = ipacl_pkg::ST_LOCKED;
              end else begin
                state_d = ipacl_pkg::S_SCAN;
              end
            end
            ipacl_pkg::FN_CLEAR: begin
              if (locked_q) begin
                res_d.status = ipacl_pkg::ST_LOCKED;
              end else begin
                count_d = '0;
              end
            end
            ipacl_pkg::FN_LOCK: begin
              locked_d = 1'b1;
            end
            ipacl_pkg::FN_CHECK: begin
              if (locked_q) begin
                case (mode_q)
                  ipacl_pkg::MODE_NONE:  res_d.allowed = 1'b1;
                  ipacl_pkg::MODE_BLACK: state_d = ipacl_pkg::S_SCAN;
                  ipacl_pkg::MODE_WHITE: state_d = ipacl_pkg::S_SCAN;
                  default:               res_d.allowed = 1'b0;
                endcase
              end
            end
            default: begin
              state_d = ipacl_pkg::S_DONE;
            end
          endcase
        end
      end

      ipacl_pkg::S_SCAN: begin
        if (rd_ptr_q != count_q) begin
          tbl_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end
        if (rd_vld_q && match) begin
          hit_d = 1'b1;
        end
        // Walk complete: last compare has been folded into hit_q.
        if (rd_ptr_q == count_q && !rd_vld_q) begin
          state_d = ipacl_pkg::S_DONE;
          if (item_q.func == ipacl_pkg::FN_ADD) begin
            if (hit_q) begin
              res_d.status = ipacl_pkg::ST_DUP;
            end else if (count_q == CNT_FULL) begin
              res_d.status = ipacl_pkg::ST_FULL;
            end else begin
              tbl_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            res_d.allowed = (mode_q == ipacl_pkg::MODE_WHITE) ? hit_q : !hit_q;
          end
        end
      end

      ipacl_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ipacl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ipacl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipacl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      locked_q    <= 1'b0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      locked_q    <= locked_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
    end
  end

  // Hold the mode once the table is locked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ipacl_pkg::MODE_NONE;
    end else if (cfg_valid_i && cfg_ready_o && !locked_q) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count beyond table depth");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock released without reset");

  a_write_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (!locked_q && count_q != CNT_FULL && state_q == ipacl_pkg::S_SCAN))
    else $error("table write while locked, full or outside a walk");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipacl_pkg::S_SCAN) |-> rd_ptr_q <= count_q)
    else $error("read pointer past last entry");

endmodule

@@ dv/ip_subnet_access_list_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the IP subnet access list.
// Drives operation beats and mode writes, predicts every result beat and compares it.
// Depends on ipacl_pkg and ip_subnet_access_list.
module ip_subnet_access_list_tb;

  localparam int unsigned ENTRIES       = ipacl_pkg::ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam logic [63:0] ONES64        = '1;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  ipacl_pkg::in_t  in_data;
  logic            in_stall;
  logic            out_valid;
  ipacl_pkg::out_t out_data;
  logic            out_stall;
  logic            cfg_valid;
  logic [1:0]      cfg_data;
  logic            cfg_ready;

  // Shadow of the block: table, lock flag and mode register.
  ipacl_pkg::entry_t acl_table [ENTRIES];
  int unsigned       acl_count;
  logic              acl_locked;
  logic [1:0]        mode_shadow;

  // Verdicts still owed by the block, oldest first.
  ipacl_pkg::out_t expected_verdicts[$];

  bit          calm;           // no gaps and no stalls while set
  int unsigned op_count[4];
  int unsigned mode_writes;
  int unsigned results_seen;
  int unsigned allowed_seen;
  int unsigned mismatches;
  int unsigned cycle_count;

  ip_subnet_access_list #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_i       (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_o      (out_data),
    .out_stall_i(out_stall),
    .cfg_valid_i(cfg_valid),
    .cfg_data_i (cfg_data),
    .cfg_ready_o(cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Work out the verdict for one accepted operation and advance the shadow
  // state. IPv4 operands keep only their low 32 bits; everything above is
  // treated as zero, so junk there must neither match nor break duplicates.
  function automatic ipacl_pkg::out_t acl_verdict(ipacl_pkg::in_t it);
    ipacl_pkg::entry_t e;
    ipacl_pkg::out_t   r;
    logic              hit;
    logic              present;
    e = '{is_v6: it.is_v6, subnet_hi: it.addr_hi, subnet_lo: it.addr_lo,
          mask_hi: it.mask_hi, mask_lo: it.mask_lo};
    if (!it.is_v6) begin
      e.subnet_hi = '0;
      e.mask_hi   = '0;
      e.subnet_lo &= ipacl_pkg::IPV4_MASK;
      e.mask_lo   &= ipacl_pkg::IPV4_MASK;
    end
    r.allowed = 1'b0;
    r.status  = ipacl_pkg::ST_DONE;
    hit       = 1'b0;
    present   = 1'b0;
    // An address hits when it differs from the subnet only outside the mask.
    for (int unsigned i = 0; i < acl_count; i++) begin
      if (acl_table[i] == e) present = 1'b1;
      if (acl_table[i].is_v6 == e.is_v6 &&
          ((e.subnet_hi ^ acl_table[i].subnet_hi) & acl_table[i].mask_hi) == '0 &&
          ((e.subnet_lo ^ acl_table[i].subnet_lo) & acl_table[i].mask_lo) == '0)
        hit = 1'b1;
    end
    case (it.func)
      ipacl_pkg::FN_ADD: begin
        // Duplicate is judged before fullness.
        if (acl_locked) r.status = ipacl_pkg::ST_LOCKED;
        else if (present) r.status = ipacl_pkg::ST_DUP;
        else if (acl_count >= ENTRIES) r.status = ipacl_pkg::ST_FULL;
        else begin
          acl_table[acl_count] = e;
          acl_count++;
        end
      end
      ipacl_pkg::FN_CLEAR: begin
        if (acl_locked) r.status = ipacl_pkg::ST_LOCKED;
        else acl_count = 0;
      end
      ipacl_pkg::FN_LOCK: begin
        acl_locked = 1'b1;
      end
      default: begin
        // Unlocked checks always deny; the reserved mode denies everything.
        if (acl_locked) begin
          case (mode_shadow)
            ipacl_pkg::MODE_NONE:  r.allowed = 1'b1;
            ipacl_pkg::MODE_BLACK: r.allowed = !hit;
            ipacl_pkg::MODE_WHITE: r.allowed = hit;
            default:               r.allowed = 1'b0;
          endcase
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Every field random; callers overwrite what matters.
  function automatic ipacl_pkg::in_t rand_item();
    ipacl_pkg::in_t it;
    it.func    = ipacl_pkg::func_e'($urandom_range(0, 3));
    it.is_v6   = 1'($urandom_range(0, 1));
    it.addr_hi = rand64();
    it.addr_lo = rand64();
    it.mask_hi = rand64();
    it.mask_lo = rand64();
    return it;
  endfunction

  // Fresh subnet, mostly with a prefix mask, sometimes with a scattered one.
  function automatic ipacl_pkg::in_t rand_subnet_add(logic v6);
    ipacl_pkg::in_t it;
    logic [127:0]   m;
    int unsigned    plen;
    it       = rand_item();
    it.func  = ipacl_pkg::FN_ADD;
    it.is_v6 = v6;
    if ($urandom_range(0, 3) != 0) begin
      // Bits above an IPv4 mask stay random.
      plen = v6 ? $urandom_range(0, 128) : $urandom_range(0, 32);
      m    = {128{1'b1}} << ((v6 ? 128 : 32) - plen);
      if (v6) {it.mask_hi, it.mask_lo} = m;
      else it.mask_lo[31:0] = m[31:0];
    end
    return it;
  endfunction

  // Re-add a stored entry; unused IPv4 bits carry fresh junk.
  function automatic ipacl_pkg::in_t replay_entry(int unsigned idx);
    ipacl_pkg::in_t it;
    it       = rand_item();
    it.func  = ipacl_pkg::FN_ADD;
    it.is_v6 = acl_table[idx].is_v6;
    if (it.is_v6) begin
      it.addr_hi = acl_table[idx].subnet_hi;
      it.addr_lo = acl_table[idx].subnet_lo;
      it.mask_hi = acl_table[idx].mask_hi;
      it.mask_lo = acl_table[idx].mask_lo;
    end else begin
      it.addr_lo[31:0] = acl_table[idx].subnet_lo[31:0];
      it.mask_lo[31:0] = acl_table[idx].mask_lo[31:0];
    end
    return it;
  endfunction

  // Check beat: mostly an address inside a stored subnet, sometimes one bit
  // off it, otherwise a random address of random type. Mask fields are junk.
  function automatic ipacl_pkg::in_t rand_probe();
    ipacl_pkg::in_t    it;
    ipacl_pkg::entry_t e;
    logic [127:0]      m;
    logic [127:0]      a;
    int unsigned       flip;
    it      = rand_item();
    it.func = ipacl_pkg::FN_CHECK;
    if (acl_count != 0 && $urandom_range(0, 9) < 7) begin
      e = acl_table[$urandom_range(0, acl_count - 1)];
      m = {e.mask_hi, e.mask_lo};
      a = ({e.subnet_hi, e.subnet_lo} & m) | ({it.addr_hi, it.addr_lo} & ~m);
      if ($urandom_range(0, 3) == 0) begin
        flip    = $urandom_range(0, e.is_v6 ? 127 : 31);
        a[flip] = ~a[flip];
      end
      it.is_v6 = e.is_v6;
      if (e.is_v6) {it.addr_hi, it.addr_lo} = a;
      else it.addr_lo[31:0] = a[31:0];
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one operation beat. Valid stays high on return so that a back-to-back
  // beat needs no second assignment in the same step; a gap lowers it first.
  task automatic send_op(input ipacl_pkg::in_t it);
    int unsigned     gap;
    ipacl_pkg::out_t verdict;
    gap = calm ? 0 : $urandom_range(0, 4);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    verdict = acl_verdict(it);
    expected_verdicts.insert(expected_verdicts.size(), verdict);
    op_count[it.func]++;
  endtask

  // Hold off the sender until every outstanding verdict has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // Write the mode register; only ever called with the block idle.
  task automatic write_mode(input logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    if (!acl_locked) mode_shadow = mode;
    mode_writes++;
  endtask

  // Random mix; weights are out of 100 and the remainder goes to checks.
  task automatic random_ops(input int unsigned n, input int unsigned w_add,
                            input int unsigned w_clear, input int unsigned w_lock);
    int unsigned    pick;
    ipacl_pkg::in_t it;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < w_add) begin
        if (acl_count != 0 && $urandom_range(0, 4) == 0)
          it = replay_entry($urandom_range(0, acl_count - 1));
        else
          it = rand_subnet_add(1'($urandom_range(0, 1)));
      end else if (pick < w_add + w_clear) begin
        it      = rand_item();
        it.func = ipacl_pkg::FN_CLEAR;
      end else if (pick < w_add + w_clear + w_lock) begin
        it      = rand_item();
        it.func = ipacl_pkg::FN_LOCK;
      end else begin
        it = rand_probe();
      end
      send_op(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed edge cases on the unlocked table.
  task automatic test_before_lock();
    ipacl_pkg::in_t it;
    calm = 1'b1;
    write_mode(MODE_RESERVED);
    write_mode(ipacl_pkg::MODE_NONE);
    // Checks before the lock deny, even with no filtering selected.
    it         = rand_item();
    it.func    = ipacl_pkg::FN_CHECK;
    it.is_v6   = 1'b0;
    send_op(it);
    it.is_v6   = 1'b1;
    it.addr_hi = ONES64;
    it.addr_lo = ONES64;
    send_op(it);
    // Clear an empty table.
    it         = rand_item();
    it.func    = ipacl_pkg::FN_CLEAR;
    send_op(it);
    // IPv4 /24 with junk above bit 31: stored with the junk dropped.
    it = '{ipacl_pkg::FN_ADD, 1'b0, ONES64, 64'hFFFF_FFFF_C0A8_0100, ONES64,
           64'hFFFF_FFFF_FFFF_FF00};
    send_op(it);
    // Same subnet under different junk is a duplicate.
    it.addr_hi        = '0;
    it.addr_lo[63:32] = 32'h1234_5678;
    it.mask_hi        = 64'h5;
    it.mask_lo[63:32] = '0;
    send_op(it);
    // Same bit pattern as IPv6 is a different entry.
    it = '{ipacl_pkg::FN_ADD, 1'b1, 64'd0, 64'hC0A8_0100, 64'd0, 64'hFFFF_FF00};
    send_op(it);
    // IPv6 catch-all and all-ones host, then the host again as a duplicate.
    it = '{ipacl_pkg::FN_ADD, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0};
    send_op(it);
    it = '{ipacl_pkg::FN_ADD, 1'b1, ONES64, ONES64, ONES64, ONES64};
    send_op(it);
    send_op(it);
    it.is_v6 = 1'b0;
    send_op(it);
    it      = rand_item();
    it.func = ipacl_pkg::FN_CHECK;
    send_op(it);
    it.func = ipacl_pkg::FN_CLEAR;
    send_op(it);
    // After the clear the host is no longer a duplicate.
    it = '{ipacl_pkg::FN_ADD, 1'b1, ONES64, ONES64, ONES64, ONES64};
    send_op(it);
    it.func = ipacl_pkg::FN_CHECK;
    send_op(it);
    calm = 1'b0;
  endtask

  // Fill the table, then overflow it; a duplicate still wins over full.
  task automatic test_table_full();
    ipacl_pkg::in_t it;
    it      = rand_item();
    it.func = ipacl_pkg::FN_CLEAR;
    send_op(it);
    while (acl_count < ENTRIES) send_op(rand_subnet_add(1'($urandom_range(0, 1))));
    send_op(rand_subnet_add(1'b1));
    send_op(rand_subnet_add(1'b0));
    send_op(replay_entry($urandom_range(0, ENTRIES - 1)));
    wait_results_drained();
    write_mode(ipacl_pkg::MODE_WHITE);
    write_mode(ipacl_pkg::MODE_BLACK);
  endtask

  // Random adds, clears and early checks on the unlocked table.
  task automatic test_table_churn();
    random_ops(150, 65, 5, 0);
    wait_results_drained();
    write_mode(ipacl_pkg::MODE_NONE);
  endtask

  // Build the final table, pick the mode that the locked phase runs under,
  // lock, and show that the table and the mode are frozen afterwards.
  task automatic test_lock();
    ipacl_pkg::in_t it;
    logic [1:0]     lock_mode;
    int unsigned    n;
    it      = rand_item();
    it.func = ipacl_pkg::FN_CLEAR;
    send_op(it);
    n = $urandom_range(8, ENTRIES);
    repeat (n) send_op(rand_subnet_add(1'($urandom_range(0, 1))));
    wait_results_drained();
    case ($urandom_range(0, 9))
      0:          lock_mode = ipacl_pkg::MODE_NONE;
      1:          lock_mode = MODE_RESERVED;
      2, 3, 4, 5: lock_mode = ipacl_pkg::MODE_BLACK;
      default:    lock_mode = ipacl_pkg::MODE_WHITE;
    endcase
    write_mode(lock_mode);
    it      = rand_item();
    it.func = ipacl_pkg::FN_LOCK;
    send_op(it);
    send_op(it);
    it.func = ipacl_pkg::FN_ADD;
    send_op(it);
    it.func = ipacl_pkg::FN_CLEAR;
    send_op(it);
    wait_results_drained();
    // Dropped by the block: the lock freezes the mode.
    write_mode(~lock_mode);
    // Address extremes of both types.
    it = '{ipacl_pkg::FN_CHECK, 1'b0, ONES64, ONES64, ONES64, ONES64};
    send_op(it);
    it.is_v6 = 1'b1;
    send_op(it);
    it = '{ipacl_pkg::FN_CHECK, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0};
    send_op(it);
    it.is_v6 = 1'b0;
    send_op(it);
  endtask

  // Mostly checks against the frozen table, with refused updates mixed in.
  task automatic test_locked_checks();
    calm = 1'b1;
    random_ops(40, 3, 2, 2);
    calm = 1'b0;
    random_ops(150, 3, 3, 2);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver back-pressure: after each result beat, draw a random stall length, none while calm is set.
  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hold = calm ? 0 : $urandom_range(0, 4);
      else if (hold != 0) hold--;
      out_stall <= (hold != 0);
    end
  end

  // Compare each result beat with the oldest outstanding verdict.
  always @(posedge clk) begin : verdict_check
    ipacl_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.allowed === 1'b1) allowed_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing outstanding: allowed %0b status %0d",
                   $time, out_data.allowed, out_data.status);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.allowed !== want.allowed || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: expected allowed %0b status %0d, got allowed %0b status %0d",
                     $time, results_seen, want.allowed, want.status,
                     out_data.allowed, out_data.status);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d verdicts outstanding",
             cycle_count, expected_verdicts.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    acl_count    = 0;
    acl_locked   = 1'b0;
    mode_shadow  = ipacl_pkg::MODE_NONE;
    calm         = 1'b0;
    mode_writes  = 0;
    results_seen = 0;
    allowed_seen = 0;
    mismatches   = 0;
    op_count     = '{default: 0};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= ipacl_pkg::MODE_NONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_before_lock();
    test_table_full();
    test_table_churn();
    test_lock();
    test_locked_checks();

    // Let the last scan finish and catch any stray beat.
    wait_results_drained();
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Ran %0d adds, %0d clears, %0d locks, %0d checks and %0d mode writes",
             op_count[ipacl_pkg::FN_ADD], op_count[ipacl_pkg::FN_CLEAR],
             op_count[ipacl_pkg::FN_LOCK], op_count[ipacl_pkg::FN_CHECK], mode_writes);
    $display("Locked with %0d entries in mode %0d; %0d results, %0d allowed, %0d mismatches",
             acl_count, mode_shadow, results_seen, allowed_seen, mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
